>>> sv/sitdt_pkg.sv
package sitdt_pkg;

	localparam int TEXT_LIMIT_DEF = 16;
	localparam int VALUE_BITS_DEF = 32;

	localparam int PAD_W  = 4;
	localparam int CHAR_W = 6;
	localparam int LEN_W  = 4;
	localparam int LEN_MAX = 15;

	// value bits folded into the BCD register per pipeline stage
	localparam int DD_STEP = 4;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;

	typedef struct packed {
		logic             neg;
		logic [LEN_W-1:0] ndig;  // significant digits, clamped to LEN_MAX
		logic [LEN_W-1:0] emit;  // characters to send, at least one
	} sitdt_len_t;

	// decimal digits needed for an unsigned number of the given width
	// (1233 / 4096 approximates log10 of 2)
	function automatic int digit_count(input int bits);
		digit_count = ((bits * 1233) >> 12) + 1;
	endfunction

endpackage

>>> sv/signed_int_to_padded_decimal_text_core.sv
// Signed integer to padded decimal text.
// Slave stream: one transfer per value, tdata holds value and pad length.
// Master stream: one transfer per character, most significant first:
// leading spaces up to the pad length (saturating at the text limit less
// one, at most 15), a minus sign for negative values, then the digits
// without leading zeros. tlast marks the final character of each value.
// Registers from the input transfer to the first character: the input stage,
// the double dabble stages, the length stage and the serialiser.
// Throughput: the pipeline takes a value every cycle unless stalled, but the
// serialiser sets the sustained rate: it sends one character per cycle while
// m_tready is high, and a value holds the output for its 1 to 15 characters.
// Reset clears every valid bit; nothing is sent until a new value arrives.
// When the receiver stalls the current character is held, the pipeline
// fills behind it and s_tready falls once every stage is occupied.
module signed_int_to_padded_decimal_text_core
	import sitdt_pkg::*;
#(
	parameter int TEXT_LIMIT = TEXT_LIMIT_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// value [VALUE_BITS-1:0], pad_length [VALUE_BITS+3:VALUE_BITS], zero fill
	input  logic [((VALUE_BITS + PAD_W + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// char_code [5:0], zero fill [7:6]
	output logic [7:0]                                m_tdata,
	output logic                                      m_tlast
);

	localparam int BCD_W = 4 * digit_count(VALUE_BITS);

	logic             mid_valid;
	logic             mid_ready;
	logic [BCD_W-1:0] mid_bcd;
	sitdt_len_t       mid_info;
	logic [CHAR_W-1:0] char_code;

	sitdt_bcd_pipe #(
		.VALUE_BITS (VALUE_BITS),
		.TEXT_LIMIT (TEXT_LIMIT)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata[VALUE_BITS-1:0]),
		.in_pad    (s_tdata[VALUE_BITS +: PAD_W]),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_bcd   (mid_bcd),
		.out_info  (mid_info)
	);

	sitdt_serial #(
		.VALUE_BITS (VALUE_BITS)
	) u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_bcd    (mid_bcd),
		.in_info   (mid_info),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (char_code),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, char_code};

endmodule

>>> sv/sitdt_bcd_pipe.sv
module sitdt_bcd_pipe
	import sitdt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int TEXT_LIMIT = TEXT_LIMIT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [VALUE_BITS-1:0]             in_value,
	input  logic [PAD_W-1:0]                  in_pad,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [4*digit_count(VALUE_BITS)-1:0] out_bcd,
	output sitdt_len_t                        out_info
);

	localparam int NDIG    = digit_count(VALUE_BITS);
	localparam int BCD_W   = 4 * NDIG;
	localparam int NDD     = (VALUE_BITS + DD_STEP - 1) / DD_STEP;
	localparam int MAG_W   = NDD * DD_STEP;
	localparam int NST     = NDD + 2;
	localparam int RAW_CAP = TEXT_LIMIT - 1;
	localparam int OUT_CAP = (RAW_CAP < LEN_MAX) ? RAW_CAP : LEN_MAX;
	localparam int NDW     = $clog2(NDIG + 2);
	localparam int CW      = (NDW > LEN_W) ? NDW : LEN_W;

	// stage 0 takes the magnitude, stages 1..NDD run double dabble,
	// the last stage works out the text length
	logic [NST-1:0] vld_s;
	logic [NST:0]   rdy;

	logic [MAG_W-1:0] mag_s1;
	logic             neg_s1;
	logic [PAD_W-1:0] pad_s1;

	logic [BCD_W-1:0] dd_bcd_s [NDD];
	logic [MAG_W-1:0] dd_rem_s [NDD];
	logic             dd_neg_s [NDD];
	logic [PAD_W-1:0] dd_pad_s [NDD];

	logic [BCD_W-1:0] bcd_sl;
	sitdt_len_t       info_sl;

	logic [VALUE_BITS-1:0] mag_in;
	sitdt_len_t            info_in;

	assign rdy[NST] = out_ready;

	for (genvar j = 0; j < NST; j++) begin : g_rdy
		assign rdy[j] = !vld_s[j] || rdy[j+1];
	end

	assign in_ready = rdy[0];

	// two's complement negate; the most negative value maps onto itself,
	// which read unsigned is the right magnitude
	assign mag_in = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			mag_s1 <= MAG_W'(mag_in);
			neg_s1 <= in_value[VALUE_BITS-1];
			pad_s1 <= in_pad;
		end
	end

	for (genvar k = 0; k < NDD; k++) begin : g_dd
		logic [BCD_W-1:0] bcd_prev;
		logic [MAG_W-1:0] rem_prev;
		logic             neg_prev;
		logic [PAD_W-1:0] pad_prev;
		logic [BCD_W-1:0] bcd_next;
		logic [MAG_W-1:0] rem_next;

		if (k == 0) begin : g_first
			assign bcd_prev = '0;
			assign rem_prev = mag_s1;
			assign neg_prev = neg_s1;
			assign pad_prev = pad_s1;
		end else begin : g_rest
			assign bcd_prev = dd_bcd_s[k-1];
			assign rem_prev = dd_rem_s[k-1];
			assign neg_prev = dd_neg_s[k-1];
			assign pad_prev = dd_pad_s[k-1];
		end

		always_comb begin
			logic [BCD_W-1:0] b;
			logic [MAG_W-1:0] r;
			b = bcd_prev;
			r = rem_prev;
			for (int s = 0; s < DD_STEP; s++) begin
				for (int d = 0; d < NDIG; d++) begin
					if (b[d*4 +: 4] >= 4'd5) begin
						b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
					end
				end
				b = {b[BCD_W-2:0], r[MAG_W-1]};
				r = {r[MAG_W-2:0], 1'b0};
			end
			bcd_next = b;
			rem_next = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (rdy[k+1]) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k+1] && vld_s[k]) begin
				dd_bcd_s[k] <= bcd_next;
				dd_rem_s[k] <= rem_next;
				dd_neg_s[k] <= neg_prev;
				dd_pad_s[k] <= pad_prev;
			end
		end
	end

	always_comb begin
		logic [CW-1:0] nd;
		logic [CW-1:0] cnt;
		logic [CW-1:0] pad_sat;
		logic [CW-1:0] total;
		logic [CW-1:0] emit;
		nd = CW'(1);
		for (int d = 0; d < NDIG; d++) begin
			if (dd_bcd_s[NDD-1][d*4 +: 4] != 4'd0) begin
				nd = CW'(d + 1);
			end
		end
		cnt     = nd + CW'(dd_neg_s[NDD-1]);
		pad_sat = (CW'(dd_pad_s[NDD-1]) > CW'(OUT_CAP)) ? CW'(OUT_CAP)
		                                                 : CW'(dd_pad_s[NDD-1]);
		total   = (cnt > pad_sat) ? cnt : pad_sat;
		emit    = (total > CW'(OUT_CAP)) ? CW'(OUT_CAP) : total;
		info_in.neg  = dd_neg_s[NDD-1];
		info_in.ndig = (nd > CW'(LEN_MAX)) ? LEN_W'(LEN_MAX) : nd[LEN_W-1:0];
		info_in.emit = emit[LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[NST-1] <= 1'b0;
		end else if (rdy[NST-1]) begin
			vld_s[NST-1] <= vld_s[NST-2];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST-1] && vld_s[NST-2]) begin
			bcd_sl  <= dd_bcd_s[NDD-1];
			info_sl <= info_in;
		end
	end

	assign out_valid = vld_s[NST-1];
	assign out_bcd   = bcd_sl;
	assign out_info  = info_sl;

endmodule

>>> sv/sitdt_serial.sv
module sitdt_serial
	import sitdt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [4*digit_count(VALUE_BITS)-1:0] in_bcd,
	input  sitdt_len_t                        in_info,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [CHAR_W-1:0]                 out_char,
	output logic                              out_last
);

	localparam int NDIG  = digit_count(VALUE_BITS);
	localparam int BCD_W = 4 * NDIG;
	// only the low positions can ever be sent
	localparam int NSEL  = (NDIG < LEN_MAX + 1) ? NDIG : LEN_MAX + 1;

	logic [BCD_W-1:0] bcd_q;
	sitdt_len_t       info_q;
	logic [LEN_W-1:0] pos_q;   // character position counted from the right
	logic             busy_q;

	logic             out_xfer;
	logic             done;
	logic             load;
	logic [3:0]       dig;

	assign out_xfer = busy_q && out_ready;
	assign done     = out_xfer && (pos_q == '0);
	assign in_ready = !busy_q || done;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= in_info.emit - 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (out_xfer) begin
			pos_q <= pos_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q  <= in_bcd;
			info_q <= in_info;
		end
	end

	always_comb begin
		dig = 4'd0;
		for (int d = 0; d < NSEL; d++) begin
			if (pos_q == LEN_W'(d)) begin
				dig = bcd_q[d*4 +: 4];
			end
		end
	end

	always_comb begin
		if (pos_q < info_q.ndig) begin
			out_char = CH_ZERO + {2'b00, dig};
		end else if (info_q.neg && (pos_q == info_q.ndig)) begin
			out_char = CH_MINUS;
		end else begin
			out_char = CH_SPACE;
		end
	end

	assign out_valid = busy_q;
	assign out_last  = busy_q && (pos_q == '0);

`ifndef ASSERT_OFF
	a_pos_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q < info_q.emit))
		else $error("character position beyond text length");

	a_step_down: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && (pos_q != '0)) |=> (busy_q && (pos_q == $past(pos_q) - 1'b1)))
		else $error("position did not step after a transfer");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_valid) |=> !busy_q)
		else $error("still busy after last character");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (out_char == CH_SPACE || out_char == CH_MINUS ||
		            (out_char >= CH_ZERO && out_char <= CH_ZERO + 6'd9)))
		else $error("character code out of range");
`endif

endmodule
